/* rtl/pot_pkg.sv */
// ----------------------------------------------------------------------------
// pot_pkg
// Shared types, codes, widths and helpers for the online perceptron trainer.
// ----------------------------------------------------------------------------
package pot_pkg;

   // Default sizing
   localparam int LANES_DEF       = 4;
   localparam int VALUE_WIDTH_DEF = 16;

   // Fixed field widths
   localparam int FEAT_W     = 16;
   localparam int SUM_W      = 36;
   localparam int LR_W       = 16;
   localparam int ACT_W      = 3;
   localparam int CSR_ADDR_W = 1;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 40;

   // Register reset values
   localparam logic [LR_W-1:0]  LR_RESET  = 16'd6554;
   localparam logic [ACT_W-1:0] ACT_RESET = 3'd2;

   // Operation codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_PREDICT      = 2'd0,
      OP_TRAIN        = 2'd1,
      OP_WRITE_WEIGHT = 2'd2,
      OP_WRITE_BIAS   = 2'd3
   } opcode_type;

   // Register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STEP_RATE     = 1'd0,
      CSR_ACTIVE_INPUTS = 1'd1
   } csr_index_type;

   // Error codes
   localparam logic signed [1:0] ERR_ZERO = 2'sb00;
   localparam logic signed [1:0] ERR_POS  = 2'sb01;
   localparam logic signed [1:0] ERR_NEG  = 2'sb11;
   localparam logic signed [1:0] ERR_BAD  = 2'sb10;

   // Update control from the merge stage
   typedef struct packed {
      logic upd_en;   // train with nonzero error, item accepted
      logic err_neg;  // error is -1
   } train_type;

   // Per-lane control
   typedef struct packed {
      logic wr_en;
      logic upd_en;
      logic err_neg;
   } lane_ctl_type;

   // One result item, predicted in bit 0
   typedef struct packed {
      logic signed [SUM_W-1:0] weighted_sum;
      logic signed [1:0]       error_value;
      logic                    predicted;
   } result_type;

   // Saturate an 18-bit signed value to a signed vw-bit range (vw <= 16)
   function automatic logic [15:0] sat_value(input logic signed [17:0] v, input int vw);
      logic signed [17:0] hi;
      logic signed [17:0] lo;
      hi = (18'sd1 <<< (vw - 1)) - 18'sd1;
      lo = -hi - 18'sd1;
      if (v > hi) begin
         return hi[15:0];
      end else if (v < lo) begin
         return lo[15:0];
      end
      return v[15:0];
   endfunction

endpackage

/* rtl/pot_lane.sv */
// ----------------------------------------------------------------------------
// pot_lane
// One feature lane: holds its weight, forms weight * feature for the sum and
// the rounded rate step for a training update.
// ----------------------------------------------------------------------------
module pot_lane #(
   parameter int VALUE_WIDTH = pot_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [pot_pkg::FEAT_W-1:0]   feature,
   input  logic                                active,
   input  pot_pkg::lane_ctl_type               ctl,
   input  logic signed [pot_pkg::FEAT_W-1:0]   wr_value,
   input  logic [pot_pkg::LR_W-1:0]            step_rate,
   output logic signed [pot_pkg::SUM_W-1:0]    product
);
   import pot_pkg::*;

   localparam int PROD_W = VALUE_WIDTH + FEAT_W;

   logic signed [VALUE_WIDTH-1:0] w_ff;
   logic signed [VALUE_WIDTH-1:0] w_in;
   logic signed [FEAT_W-1:0]      x;
   logic signed [PROD_W-1:0]      prod_full;
   logic signed [FEAT_W:0]        x_ext;
   logic [FEAT_W:0]               mag;
   logic [32:0]                   lr_prod;
   logic [33:0]                   round_sum;
   logic [16:0]                   step_mag;
   logic signed [17:0]            step;
   logic signed [17:0]            upd_sum;
   logic [15:0]                   upd_sat;
   logic [15:0]                   wr_sat;

   // Masked feature and product term for the sum
   assign x         = active ? feature : '0;
   assign prod_full = w_ff * x;
   assign product   = {{(SUM_W - PROD_W){prod_full[PROD_W-1]}}, prod_full};

   // Step magnitude: rate * |x| rounded from Q8.24 to Q8.8, ties away from zero
   assign x_ext     = {x[FEAT_W-1], x};
   assign mag       = (FEAT_W + 1)'(x[FEAT_W-1] ? -x_ext : x_ext);
   assign lr_prod   = 33'(step_rate) * 33'(mag);
   assign round_sum = 34'(lr_prod) + 34'd32768;
   assign step_mag  = round_sum[32:16];

   // Signed step and saturated sums
   assign step    = (x[FEAT_W-1] != ctl.err_neg) ? -$signed({1'b0, step_mag})
                                                  : $signed({1'b0, step_mag});
   assign upd_sum = $signed({{(18 - VALUE_WIDTH){w_ff[VALUE_WIDTH-1]}}, w_ff}) + step;
   assign upd_sat = sat_value(upd_sum, VALUE_WIDTH);
   assign wr_sat  = sat_value({{2{wr_value[FEAT_W-1]}}, wr_value}, VALUE_WIDTH);

   // Weight next value
   always_comb begin
      w_in = w_ff;
      if (ctl.wr_en) begin
         w_in = wr_sat[VALUE_WIDTH-1:0];
      end else if (ctl.upd_en) begin
         w_in = upd_sat[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
      end else begin
         w_ff <= w_in;
      end
   end

   // Weight changes only on a write or a training update
   a_weight_hold: assert property (@(posedge clock) disable iff (reset)
      (!ctl.wr_en && !ctl.upd_en) |=> $stable(w_ff))
      else $error("weight changed without write or update");

   // An inactive lane never moves its weight on an update
   a_idle_lane: assert property (@(posedge clock) disable iff (reset)
      (!active && !ctl.wr_en && ctl.upd_en) |=> $stable(w_ff))
      else $error("inactive lane weight moved");

   // Inactive lane contributes nothing to the sum
   a_idle_product: assert property (@(posedge clock) disable iff (reset)
      (!active) |-> (product == '0))
      else $error("inactive lane gave a nonzero product");

endmodule

/* rtl/pot_merge.sv */
// ----------------------------------------------------------------------------
// pot_merge
// Adds the lane products and the scaled bias, applies the step activation,
// derives the error and owns the bias register.
// ----------------------------------------------------------------------------
module pot_merge #(
   parameter int LANES       = pot_pkg::LANES_DEF,
   parameter int VALUE_WIDTH = pot_pkg::VALUE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  pot_pkg::opcode_type                opcode,
   input  logic                               target,
   input  logic signed [pot_pkg::FEAT_W-1:0]  wr_value,
   input  logic [pot_pkg::LR_W-1:0]           step_rate,
   input  logic signed [pot_pkg::SUM_W-1:0]   products [LANES],
   output pot_pkg::train_type                 train,
   output pot_pkg::result_type                result
);
   import pot_pkg::*;

   logic signed [VALUE_WIDTH-1:0] bias_ff;
   logic signed [VALUE_WIDTH-1:0] bias_in;
   logic signed [SUM_W-1:0]       sum;
   logic                          pred;
   logic                          is_train;
   logic                          is_calc;
   logic [16:0]                   lr_round;
   logic [8:0]                    bstep;
   logic signed [17:0]            bias_ext;
   logic signed [17:0]            bias_upd;
   logic [15:0]                   upd_sat;
   logic [15:0]                   wr_sat;

   // Bias * 256 plus the products of all lanes
   always_comb begin
      sum = $signed({{(SUM_W - VALUE_WIDTH){bias_ff[VALUE_WIDTH-1]}}, bias_ff}) <<< 8;
      for (int i = 0; i < LANES; i++) begin
         sum = sum + products[i];
      end
   end

   // Activation and error
   assign pred          = ~sum[SUM_W-1];
   assign is_train      = (opcode == OP_TRAIN);
   assign is_calc       = (opcode == OP_PREDICT) || is_train;
   assign train.upd_en  = accept && is_train && (target != pred);
   assign train.err_neg = pred;

   always_comb begin
      result = '0;
      if (is_calc) begin
         result.predicted    = pred;
         result.weighted_sum = sum;
         if (is_train && (target != pred)) begin
            result.error_value = pred ? ERR_NEG : ERR_POS;
         end else begin
            result.error_value = ERR_ZERO;
         end
      end
   end

   // Bias step: step rate rounded from Q0.16 to Q8.8
   assign lr_round = 17'(step_rate) + 17'd128;
   assign bstep    = lr_round[16:8];
   assign bias_ext = $signed({{(18 - VALUE_WIDTH){bias_ff[VALUE_WIDTH-1]}}, bias_ff});
   assign bias_upd = pred ? (bias_ext - $signed({9'd0, bstep}))
                          : (bias_ext + $signed({9'd0, bstep}));
   assign upd_sat  = sat_value(bias_upd, VALUE_WIDTH);
   assign wr_sat   = sat_value({{2{wr_value[FEAT_W-1]}}, wr_value}, VALUE_WIDTH);

   // Bias next value
   always_comb begin
      bias_in = bias_ff;
      if (accept && (opcode == OP_WRITE_BIAS)) begin
         bias_in = wr_sat[VALUE_WIDTH-1:0];
      end else if (train.upd_en) begin
         bias_in = upd_sat[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else begin
         bias_ff <= bias_in;
      end
   end

   // Bias is held while no transaction is taken
   a_bias_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(bias_ff))
      else $error("bias changed without a transaction");

   // A predict never touches the bias
   a_predict_bias: assert property (@(posedge clock) disable iff (reset)
      (accept && (opcode == OP_PREDICT)) |=> $stable(bias_ff))
      else $error("predict changed the bias");

   // Update requested only on a train with a mismatch
   a_upd_train: assert property (@(posedge clock) disable iff (reset)
      train.upd_en |-> (is_train && (result.error_value != ERR_ZERO)))
      else $error("update without training error");

endmodule

/* rtl/perceptron_online_trainer_unit.sv */
// ----------------------------------------------------------------------------
// perceptron_online_trainer_unit
// Single-layer perceptron with step activation and online learning rule.
// ----------------------------------------------------------------------------
// One transaction is taken per clock while req_tready is high, including
// back-to-back train operations: each lane multiplies its weight by its
// feature in the same cycle that the merge stage adds the lanes, decides the
// class and commits the weight and bias updates, so the next item already
// sees the updated model. The result is registered on acceptance. Results
// leave through a two-entry output buffer; req_tready falls only when both
// entries are full, so a stalled result port costs no input cycle until then.
// Reset is synchronous and clears all weights and the bias.
module perceptron_online_trainer_unit #(
   parameter int LANES       = pot_pkg::LANES_DEF,
   parameter int VALUE_WIDTH = pot_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // features[63:0], target[64], weight_index[66:65], write_value[82:67]
   input  logic [pot_pkg::REQ_DATA_W-1:0]        req_tdata,
   // opcode[1:0]
   input  logic [1:0]                            req_tuser,
   // Result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // predicted[0], error_value[2:1], weighted_sum[38:3]
   output logic [pot_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // Configuration
   input  logic                                  csr_we,
   input  logic [pot_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [pot_pkg::LR_W-1:0]              csr_wdata
);
   import pot_pkg::*;

   logic [LR_W-1:0]         lr_ff;
   logic [ACT_W-1:0]        act_ff;
   logic                    req_acc;
   logic                    rsp_take;
   opcode_type              opcode;
   logic                    target;
   logic [1:0]              weight_index;
   logic signed [FEAT_W-1:0] write_value;
   logic signed [SUM_W-1:0] products [LANES];
   train_type               train;
   result_type              result;
   result_type              out_ff;
   result_type              out_in;
   logic                    out_vld_ff;
   logic                    out_vld_in;
   result_type              skid_ff;
   result_type              skid_in;
   logic                    skid_vld_ff;
   logic                    skid_vld_in;

   // Field unpacking
   assign opcode       = opcode_type'(req_tuser);
   assign target       = req_tdata[64];
   assign weight_index = req_tdata[66:65];
   assign write_value  = $signed(req_tdata[82:67]);

   assign req_tready = ~skid_vld_ff;
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_take   = out_vld_ff & rsp_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= LR_RESET;
         act_ff <= ACT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_STEP_RATE:     lr_ff  <= csr_wdata;
            CSR_ACTIVE_INPUTS: act_ff <= csr_wdata[ACT_W-1:0];
            default: ;
         endcase
      end
   end

   // Feature lanes
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      lane_ctl_type lane_ctl;

      assign lane_ctl.wr_en   = req_acc && (opcode == OP_WRITE_WEIGHT) &&
                                ({1'b0, weight_index} == 3'(i));
      assign lane_ctl.upd_en  = train.upd_en;
      assign lane_ctl.err_neg = train.err_neg;

      pot_lane #(
         .VALUE_WIDTH(VALUE_WIDTH)
      ) u_lane (
         .clock         (clock),
         .reset         (reset),
         .feature       ($signed(req_tdata[FEAT_W*i +: FEAT_W])),
         .active        (3'(i) < act_ff),
         .ctl           (lane_ctl),
         .wr_value      (write_value),
         .step_rate     (lr_ff),
         .product       (products[i])
      );
   end

   // Sum, activation and bias
   pot_merge #(
      .LANES      (LANES),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_acc),
      .opcode        (opcode),
      .target        (target),
      .wr_value      (write_value),
      .step_rate     (lr_ff),
      .products      (products),
      .train         (train),
      .result        (result)
   );

   // Two-entry output buffer
   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (rsp_take || !out_vld_ff) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_in     = result;
            skid_vld_in = req_acc;
         end else begin
            out_in      = result;
            out_vld_in  = req_acc;
         end
      end else if (req_acc) begin
         skid_in     = result;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_ff};

   // Skid entry is only occupied behind a full output entry
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry full while output entry empty");

   // Error code is never the unused pattern
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:1] != ERR_BAD))
      else $error("invalid error code");

   // A nonzero error goes with the class taken from the sum sign
   a_err_pred: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:1] != ERR_ZERO)) |-> (rsp_tdata[0] == ~rsp_tdata[38]))
      else $error("error disagrees with weighted sum sign");

   // A positive error means the class was predicted as zero
   a_err_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:1] == ERR_POS)) |-> !rsp_tdata[0])
      else $error("positive error with predicted one");

endmodule
